FILE: design/htsb_pkg.sv
// Package for the sorted-bucket hash table: sizes, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps
package htsb_pkg;
    localparam int MAX_BUCKETS  = 64;
    localparam int BUCKET_DEPTH = 8;
    localparam int KEY_BITS     = 31;
    localparam int BKT_W  = $clog2(MAX_BUCKETS);
    localparam int SLOT_W = $clog2(BUCKET_DEPTH);
    localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
    localparam int ADDR_W = BKT_W + SLOT_W;
    localparam int CNT_W  = 7;
    localparam int POS_W  = 4;

    typedef logic [KEY_BITS-1:0] key_t;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_SEARCH = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;
    localparam logic [2:0] OP_LIST   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_BADBKT   = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        key_t       key;
        key_t       new_key;
        logic [5:0] bucket;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] bucket_index;
        logic [3:0] position;
        key_t       listed_key;
        logic       last;
    } rsp_t;
endpackage

FILE: design/htsb_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on htsb_pkg.
`timescale 1ns / 1ps
interface htsb_req_if import htsb_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    key_t       key;
    key_t       new_key;
    logic [5:0] bucket;
    modport source (output valid, kind, key, new_key, bucket, input ready);
    modport sink   (input valid, kind, key, new_key, bucket, output ready);
endinterface

interface htsb_rsp_if import htsb_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [5:0] bucket_index;
    logic [3:0] position;
    key_t       listed_key;
    logic       last;
    modport source (output valid, status, bucket_index, position, listed_key, last,
                    input ready);
    modport sink   (input valid, status, bucket_index, position, listed_key, last,
                    output ready);
endinterface

FILE: design/hash_table_sorted_buckets.sv
// Top level of the sorted-bucket hash table: channels, bucket_count register, core.
// Depends on htsb_pkg, htsb_if and htsb_core.
`timescale 1ns / 1ps
// Keys hash to bucket (key mod bucket_count); each bucket is an ascending list of up
// to 8 keys in a 512-entry key memory, with per-bucket counts in a 64-entry memory.
// After reset the block zeroes the counts before it takes a word.
// Words are handled one at a time. Every keyed word runs two 31-step bit-serial
// hashes back to back (key, then new key), then scan, delete and shift passes that
// step slot by slot through the bucket over the single key memory read port. A list
// word reads the fill count, then the listed keys one by one; a bad-bucket list is
// answered without reading the table. Output stalls hold the block up.
// Results leave through an output register.
module hash_table_sorted_buckets import htsb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    htsb_req_if.sink   in_ch,
    htsb_rsp_if.source out_ch
);
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] eff_count;
    req_t req;
    rsp_t rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) count_reg <= CNT_W'(MAX_BUCKETS);
        else if (cfg_we) count_reg <= cfg_wdata;
    end

    // zero counts as one, above the table size clamps
    assign eff_count = (count_reg == '0) ? CNT_W'(1)
                     : (count_reg > CNT_W'(MAX_BUCKETS)) ? CNT_W'(MAX_BUCKETS) : count_reg;

    assign req.kind    = in_ch.kind;
    assign req.key     = in_ch.key;
    assign req.new_key = in_ch.new_key;
    assign req.bucket  = in_ch.bucket;

    htsb_core u_core (
        .clk(clk), .rst_n(rst_n), .eff_count(eff_count),
        .req_valid(in_ch.valid), .req_ready(in_ch.ready), .req(req),
        .rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready), .rsp(rsp)
    );

    assign out_ch.status       = rsp.status;
    assign out_ch.bucket_index = rsp.bucket_index;
    assign out_ch.position     = rsp.position;
    assign out_ch.listed_key   = rsp.listed_key;
    assign out_ch.last         = rsp.last;
endmodule

FILE: design/htsb_mod.sv
// Iterative key modulo bucket count: one restoring-division bit per cycle.
// Depends on htsb_pkg.
`timescale 1ns / 1ps
module htsb_mod import htsb_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  key_t             dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [BKT_W-1:0] rem
);
    localparam int STEP_W = $clog2(KEY_BITS + 1);

    logic [CNT_W-1:0]  rem_reg;
    key_t              quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    trial;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[KEY_BITS-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(KEY_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[KEY_BITS-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_reg <= CNT_W'(trial - {1'b0, divisor});
            else
                rem_reg <= trial[CNT_W-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[BKT_W-1:0];
endmodule

FILE: design/htsb_core.sv
// Sequencer over the key memory and the fill-count memory.
// Depends on htsb_pkg and htsb_mod.
`timescale 1ns / 1ps
module htsb_core import htsb_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] eff_count,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp
);
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_HASH1, S_HASH2, S_FILL, S_FILLW, S_SCAN, S_SCANW,
        S_DECIDE, S_NFILL, S_NFILLW, S_NSCAN, S_NSCANW, S_DEL, S_DELW,
        S_INS, S_INSW, S_LIST, S_LISTW, S_OUT
    } state_t;

    state_t state_reg;
    req_t   req_reg;
    logic [BKT_W-1:0]  b_reg, nb_reg;
    logic [FILL_W-1:0] n_reg, nn_reg;
    logic [SLOT_W:0]   i_reg;
    logic [BKT_W-1:0]  clr_reg;   // count clearing pointer
    logic [SLOT_W:0]   pos_reg;   // found slot, index of key
    logic              found_reg, nfound_reg;
    logic [SLOT_W:0]   ins_reg;   // insertion point
    key_t              carry_reg;
    rsp_t              res_reg;   // single result staged for S_OUT
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;
    logic              list_reg;

    // memories
    key_t              key_mem [MAX_BUCKETS*BUCKET_DEPTH];
    logic [FILL_W-1:0] fill_mem [MAX_BUCKETS];
    key_t              kq;
    logic [FILL_W-1:0] fq;
    logic              kwe, fwe;
    logic [ADDR_W-1:0] kra, kwa;
    logic [BKT_W-1:0]  fra, fwa;
    key_t              kwd;
    logic [FILL_W-1:0] fwd;

    always_ff @(posedge clk)
    begin
        if (kwe) key_mem[kwa] <= kwd;
        kq <= key_mem[kra];
        if (fwe) fill_mem[fwa] <= fwd;
        fq <= fill_mem[fra];
    end

    // divider
    logic mstart, mdone;
    key_t mdiv;
    logic [BKT_W-1:0] mrem;
    htsb_mod u_mod (.clk(clk), .rst_n(rst_n), .start(mstart), .dividend(mdiv),
                    .divisor(eff_count), .done(mdone), .rem(mrem));

    logic [BKT_W-1:0] cur_b;
    key_t             cur_key;
    logic [FILL_W-1:0] cur_n;
    logic nscan, nsame;

    always_comb
    begin
        nscan   = (state_reg == S_NSCAN) || (state_reg == S_NSCANW);
        cur_b   = nscan ? nb_reg : b_reg;
        cur_key = nscan ? req_reg.new_key : req_reg.key;
        cur_n   = nscan ? nn_reg : n_reg;
        nsame   = (nb_reg == b_reg);
        mstart  = (state_reg == S_IDLE && req_valid) || (state_reg == S_HASH1 && mdone);
        mdiv    = (state_reg == S_IDLE) ? req.key : req_reg.new_key;
        kra = {cur_b, i_reg[SLOT_W-1:0]};
        fra = (state_reg == S_NFILL) ? nb_reg
            : (state_reg == S_IDLE || state_reg == S_HASH1 || state_reg == S_HASH2) ? mrem
            : b_reg;
        kwe = 1'b0; kwa = '0; kwd = carry_reg;
        fwe = 1'b0; fwa = cur_b; fwd = '0;
        case (state_reg)
            S_CLEAR: begin fwe = 1'b1; fwa = clr_reg; fwd = '0; end
            S_DEL:
            begin
                kra = {b_reg, SLOT_W'(i_reg + 1'b1)};
            end
            S_DELW:
            begin
                kwe = 1'b1; kwa = {b_reg, i_reg[SLOT_W-1:0]}; kwd = kq;
            end
            S_INSW:
            begin
                // locate pass only reads; shift pass moves slot i-1 up into slot i
                kwe = !list_reg; kwa = {nb_reg, i_reg[SLOT_W-1:0]};
                kwd = (i_reg > ins_reg) ? kq : carry_reg;
            end
            S_INS:
                kra = list_reg ? {nb_reg, i_reg[SLOT_W-1:0]}
                               : {nb_reg, SLOT_W'(i_reg - 1'b1)};
            default: ;
        endcase
        if (state_reg == S_DECIDE && req_reg.kind == OP_DELETE && found_reg)
        begin
            fwe = 1'b1; fwa = b_reg; fwd = n_reg - 1'b1;
        end
        if (state_reg == S_DECIDE && req_reg.kind == OP_INSERT && !found_reg
            && n_reg != FILL_W'(BUCKET_DEPTH))
        begin
            fwe = 1'b1; fwa = b_reg; fwd = n_reg + 1'b1;
        end
        if (state_reg == S_NSCANW && i_reg == cur_n && req_reg.kind == OP_UPDATE
            && !nfound_reg && !(nsame == 1'b0 && nn_reg == FILL_W'(BUCKET_DEPTH)))
        begin
            // update fills: new bucket gains one here; the same bucket keeps its count
            fwe = 1'b1; fwa = nb_reg; fwd = nsame ? nn_reg : nn_reg + 1'b1;
        end
        if (state_reg == S_DEL && i_reg + 1'b1 >= n_reg && req_reg.kind == OP_UPDATE
            && !nsame)
        begin
            // update fills: old bucket loses one
            fwe = 1'b1; fwa = b_reg; fwd = n_reg - 1'b1;
        end
    end

    function automatic rsp_t mk(input logic [2:0] st, input logic [BKT_W-1:0] bi,
                                input logic [SLOT_W:0] p, input key_t lk,
                                input logic lst);
        rsp_t r;
        r.status = st;
        r.bucket_index = 6'(bi);
        r.position = POS_W'(p);
        r.listed_key = lk;
        r.last = lst;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            i_reg <= '0;
            clr_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready) rsp_valid_reg <= 1'b0;
            case (state_reg)
                // fill counts start at zero
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == BKT_W'(MAX_BUCKETS - 1))
                    begin
                        state_reg <= S_IDLE;
                        i_reg <= '0;
                    end
                end
                S_IDLE:
                    if (req_valid)
                    begin
                        req_reg <= req;
                        found_reg <= 1'b0; nfound_reg <= 1'b0;
                        state_reg <= (req.kind == OP_LIST) ? S_FILL : S_HASH1;
                        list_reg <= (req.kind == OP_LIST);
                        b_reg <= req.bucket[BKT_W-1:0];
                        if (req.kind > OP_LIST) state_reg <= S_IDLE;
                        if (req.kind == OP_LIST && {1'b0, req.bucket} >= eff_count)
                        begin
                            res_reg <= mk(ST_BADBKT, '0, '0, '0, 1'b1);
                            state_reg <= S_OUT;
                        end
                    end
                S_HASH1:
                    if (mdone)
                    begin
                        b_reg <= mrem;
                        state_reg <= S_HASH2;
                    end
                S_HASH2:
                    if (mdone)
                    begin
                        nb_reg <= mrem;
                        state_reg <= S_FILL;
                    end
                S_FILL: state_reg <= S_FILLW;
                S_FILLW:
                begin
                    n_reg <= fq;
                    i_reg <= '0;
                    ins_reg <= {1'b0, fq[SLOT_W-1:0]} | ((fq == FILL_W'(BUCKET_DEPTH)) ?
                               (SLOT_W+1)'(BUCKET_DEPTH) : '0);
                    if (list_reg)
                    begin
                        if (fq == '0)
                        begin
                            res_reg <= mk(ST_EMPTY, '0, '0, '0, 1'b1);
                            state_reg <= S_OUT;
                        end
                        else state_reg <= S_LIST;
                    end
                    else state_reg <= S_SCAN;
                end
                // linear scan, one read per slot, with a wait state after each
                S_SCAN, S_NSCAN:
                    if (i_reg == cur_n) state_reg <= (nscan ? S_NSCANW : S_SCANW);
                    else state_reg <= (nscan ? S_NSCANW : S_SCANW);
                S_SCANW, S_NSCANW:
                begin
                    if (i_reg != cur_n)
                    begin
                        if (kq == cur_key)
                        begin
                            if (nscan) nfound_reg <= 1'b1;
                            else begin found_reg <= 1'b1; pos_reg <= i_reg; end
                        end
                        if (nscan && kq > cur_key && i_reg < ins_reg) ins_reg <= i_reg;
                        if (!nscan && kq > cur_key && i_reg < ins_reg) ins_reg <= i_reg;
                        i_reg <= i_reg + 1'b1;
                        state_reg <= nscan ? S_NSCAN : S_SCAN;
                    end
                    else if (nscan)
                    begin
                        if (nfound_reg)
                        begin
                            res_reg <= mk(ST_NOTFOUND, '0, '0, '0, 1'b1);
                            state_reg <= S_OUT;
                        end
                        else if (!nsame && nn_reg == FILL_W'(BUCKET_DEPTH))
                        begin
                            res_reg <= mk(ST_FULL, '0, '0, '0, 1'b1);
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            res_reg <= mk(ST_OK, b_reg, pos_reg + 1'b1, '0, 1'b1);
                            // remove first, then place
                            i_reg <= pos_reg;
                            state_reg <= S_DEL;
                        end
                    end
                    else state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    case (req_reg.kind)
                        OP_INSERT:
                            if (found_reg)
                            begin
                                res_reg <= mk(ST_NOTFOUND, '0, '0, '0, 1'b1);
                                state_reg <= S_OUT;
                            end
                            else if (n_reg == FILL_W'(BUCKET_DEPTH))
                            begin
                                res_reg <= mk(ST_FULL, '0, '0, '0, 1'b1);
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                nb_reg <= b_reg; nn_reg <= n_reg + 1'b1;
                                carry_reg <= req_reg.key;
                                i_reg <= {1'b0, n_reg[SLOT_W-1:0]};
                                state_reg <= S_INS;
                            end
                        OP_SEARCH, OP_DELETE:
                            if (!found_reg)
                            begin
                                res_reg <= mk(ST_NOTFOUND, '0, '0, '0, 1'b1);
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                res_reg <= mk(ST_OK, b_reg, pos_reg + 1'b1, '0, 1'b1);
                                if (req_reg.kind == OP_DELETE)
                                begin
                                    i_reg <= pos_reg; nn_reg <= '0;
                                    state_reg <= S_DEL;
                                end
                                else state_reg <= S_OUT;
                            end
                        OP_UPDATE:
                            if (!found_reg)
                            begin
                                res_reg <= mk(ST_NOTFOUND, '0, '0, '0, 1'b1);
                                state_reg <= S_OUT;
                            end
                            else state_reg <= S_NFILL;
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_NFILL: state_reg <= S_NFILLW;
                S_NFILLW:
                begin
                    nn_reg <= fq;
                    i_reg <= '0;
                    state_reg <= S_NSCAN;
                end
                // close the gap left by the removed key
                S_DEL:
                    if (i_reg + 1'b1 >= n_reg)
                    begin
                        if (req_reg.kind == OP_UPDATE)
                        begin
                            carry_reg <= req_reg.new_key;
                            n_reg <= n_reg - 1'b1;
                            if (nsame) nn_reg <= n_reg - 1'b1;
                            state_reg <= S_INS;
                            // rescan insertion point in the new bucket
                            i_reg <= '0;
                            ins_reg <= '1;
                            list_reg <= 1'b1;
                        end
                        else state_reg <= S_OUT;
                    end
                    else state_reg <= S_DELW;
                S_DELW:
                begin
                    i_reg <= i_reg + 1'b1;
                    state_reg <= S_DEL;
                end
                // shift right from the top slot down to the insertion point
                S_INS: state_reg <= S_INSW;
                S_INSW:
                begin
                    if (list_reg)
                    begin
                        // update path: locate insertion point
                        if (i_reg == nn_reg || kq > carry_reg)
                        begin
                            ins_reg <= i_reg;
                            list_reg <= 1'b0;
                            i_reg <= {1'b0, nn_reg[SLOT_W-1:0]};
                            nn_reg <= nn_reg + 1'b1;
                            state_reg <= S_INS;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            state_reg <= S_INS;
                        end
                    end
                    else if (i_reg <= ins_reg)
                        state_reg <= (req_reg.kind == OP_UPDATE) ? S_OUT : S_IDLE;
                    else
                    begin
                        i_reg <= i_reg - 1'b1;
                        state_reg <= S_INS;
                    end
                end
                S_LIST: state_reg <= S_LISTW;
                S_LISTW:
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg <= mk(ST_OK, b_reg, i_reg + 1'b1, kq,
                                      (i_reg + 1'b1) == n_reg);
                        rsp_valid_reg <= 1'b1;
                        i_reg <= i_reg + 1'b1;
                        state_reg <= ((i_reg + 1'b1) == n_reg) ? S_IDLE : S_LIST;
                    end
                S_OUT:
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
endmodule

FILE: tb/tb_hash_table_sorted_buckets.sv
// Testbench for the sorted-bucket hash table: directed and random operation words
// checked against an in-bench model of the buckets. Depends on htsb_pkg, htsb_if
// and the hash_table_sorted_buckets top level.
`timescale 1ns / 1ps
module tb_hash_table_sorted_buckets;
    import htsb_pkg::*;

    localparam int      IDLE_LIMIT = 6000;
    localparam int      SETTLE_CYC = 200;
    localparam int      LONG_HOLD  = 400;
    localparam key_t    KEY_TOP    = {KEY_BITS{1'b1}};

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;

    htsb_req_if req_ch ();
    htsb_rsp_if rsp_ch ();

    hash_table_sorted_buckets i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (req_ch),
        .out_ch    (rsp_ch)
    );

    // table model
    key_t          bucket_keys [MAX_BUCKETS][BUCKET_DEPTH];
    int            bucket_len  [MAX_BUCKETS];
    int            modulus_reg;
    rsp_t          pending_rsp [$];

    int   mismatches;
    int   words_sent;
    int   results_seen;
    int   idle_cycles;
    int   hold_request;
    key_t key_pool [24];

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int live_buckets();
        if (modulus_reg == 0)
            return 1;
        if (modulus_reg > MAX_BUCKETS)
            return MAX_BUCKETS;
        return modulus_reg;
    endfunction

    function automatic int slot_of(int b, key_t k);
        for (int i = 0; i < bucket_len[b]; i++)
            if (bucket_keys[b][i] == k)
                return i;
        return -1;
    endfunction

    function automatic void push_status(logic [2:0] st);
        rsp_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        pending_rsp.push_back(r);
    endfunction

    function automatic void push_hit(int b, int s);
        rsp_t r;
        r = '0;
        r.status = ST_OK;
        r.bucket_index = b[5:0];
        r.position = 4'(s + 1);
        r.last = 1'b1;
        pending_rsp.push_back(r);
    endfunction

    // sorted insert; caller knows the key is absent and there is room
    function automatic void place_key(int b, key_t k);
        int i;
        i = 0;
        while (i < bucket_len[b] && bucket_keys[b][i] < k)
            i++;
        for (int j = bucket_len[b]; j > i; j--)
            bucket_keys[b][j] = bucket_keys[b][j-1];
        bucket_keys[b][i] = k;
        bucket_len[b]++;
    endfunction

    function automatic void drop_slot(int b, int s);
        for (int j = s; j + 1 < bucket_len[b]; j++)
            bucket_keys[b][j] = bucket_keys[b][j+1];
        bucket_len[b]--;
    endfunction

    // expected results of one accepted word
    function automatic void table_step(logic [2:0] kind, key_t k, key_t nk, logic [5:0] lb);
        int   b;
        int   nb;
        int   s;
        rsp_t r;
        b = int'(longint'(k) % live_buckets());
        nb = int'(longint'(nk) % live_buckets());
        case (kind)
            OP_INSERT:
            begin
                if (slot_of(b, k) >= 0)
                    push_status(ST_NOTFOUND);
                else if (bucket_len[b] >= BUCKET_DEPTH)
                    push_status(ST_FULL);
                else
                    place_key(b, k);
            end
            OP_SEARCH, OP_DELETE:
            begin
                s = slot_of(b, k);
                if (s < 0)
                    push_status(ST_NOTFOUND);
                else
                begin
                    push_hit(b, s);
                    if (kind == OP_DELETE)
                        drop_slot(b, s);
                end
            end
            OP_UPDATE:
            begin
                s = slot_of(b, k);
                if (s < 0 || slot_of(nb, nk) >= 0)
                    push_status(ST_NOTFOUND);
                else if (nb != b && bucket_len[nb] >= BUCKET_DEPTH)
                    push_status(ST_FULL);
                else
                begin
                    push_hit(b, s);
                    drop_slot(b, s);
                    place_key(nb, nk);
                end
            end
            OP_LIST:
            begin
                if (int'(lb) >= live_buckets())
                    push_status(ST_BADBKT);
                else if (bucket_len[lb] == 0)
                    push_status(ST_EMPTY);
                else
                    for (int i = 0; i < bucket_len[lb]; i++)
                    begin
                        r = '0;
                        r.status = ST_OK;
                        r.bucket_index = lb;
                        r.position = 4'(i + 1);
                        r.listed_key = bucket_keys[lb][i];
                        r.last = (i + 1 == bucket_len[lb]);
                        pending_rsp.push_back(r);
                    end
            end
            default:
            begin
            end
        endcase
    endfunction

    // offer one word after a random gap; returns at the accepting edge
    task automatic send_word(logic [2:0] kind, key_t k, key_t nk, logic [5:0] lb);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 4) == 0)
            gap = 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= kind;
        req_ch.key     <= k;
        req_ch.new_key <= nk;
        req_ch.bucket  <= lb;
        do
            @(posedge clk);
        while (!req_ch.ready);
        table_step(kind, k, nk, lb);
        words_sent++;
    endtask

    // wait for every result, then let a word that gives none finish
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_buckets(logic [6:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        modulus_reg = v;
    endtask

    // result checker with random receiver stalls
    initial
    begin
        int   stall;
        rsp_t got;
        rsp_t want;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            else if ($urandom_range(0, 3) == 0)
                stall = 0;
            else
                stall = $urandom_range(0, 13);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rst_n));
            results_seen++;
            got.status       = rsp_ch.status;
            got.bucket_index = rsp_ch.bucket_index;
            got.position     = rsp_ch.position;
            got.listed_key   = rsp_ch.listed_key;
            got.last         = rsp_ch.last;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %p", got);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // extremes of keys, every operation, hits and misses
    task automatic test_operations();
        send_word(OP_LIST, 0, 0, 6'd0);
        send_word(OP_INSERT, 0, 0, 0);
        send_word(OP_INSERT, KEY_TOP, 0, 0);
        send_word(OP_INSERT, 64, 0, 0);
        send_word(OP_INSERT, 64, 0, 0);
        send_word(OP_SEARCH, KEY_TOP, 0, 0);
        send_word(OP_SEARCH, 128, 0, 0);
        send_word(OP_LIST, 0, 0, 6'd0);
        send_word(OP_LIST, 0, 0, 6'd63);
        send_word(OP_UPDATE, 64, key_t'(KEY_TOP - 1'b1), 0);
        send_word(OP_UPDATE, 5, 7, 0);
        send_word(OP_UPDATE, 0, KEY_TOP, 0);
        send_word(OP_DELETE, 0, 0, 0);
        send_word(OP_DELETE, 0, 0, 0);
        for (int kd = 5; kd < 8; kd++)
            send_word(3'(kd), KEY_TOP, KEY_TOP, 6'd63);
        send_word(OP_LIST, 0, 0, 6'd62);
    endtask

    // one bucket filled to the top, then full inserts and updates
    task automatic test_full_bucket();
        set_buckets(7'd2);
        for (int i = 0; i < BUCKET_DEPTH + 1; i++)
            send_word(OP_INSERT, key_t'(2 * i + 1000), 0, 0);
        send_word(OP_INSERT, 1, 0, 0);
        send_word(OP_UPDATE, 1, 4000, 0);
        send_word(OP_UPDATE, 1000, 4000, 0);
        send_word(OP_LIST, 0, 0, 6'd0);
        send_word(OP_LIST, 0, 0, 6'd2);
    endtask

    // receiver holds off while the sender keeps offering lists
    task automatic test_backpressure();
        drain();
        hold_request = LONG_HOLD;
        for (int i = 0; i < 12; i++)
            send_word(OP_LIST, 0, 0, 6'd0);
    endtask

    task automatic test_random(logic [6:0] count, int words);
        logic [2:0] kind;
        key_t       k;
        key_t       nk;
        int         pick;
        set_buckets(count);
        for (int i = 0; i < 24; i++)
            key_pool[i] = (i < 4) ? key_t'($urandom) : key_t'($urandom_range(0, 300));
        for (int i = 0; i < words; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                kind = OP_INSERT;
            else if (pick < 50)
                kind = OP_SEARCH;
            else if (pick < 65)
                kind = OP_DELETE;
            else if (pick < 80)
                kind = OP_UPDATE;
            else if (pick < 96)
                kind = OP_LIST;
            else
                kind = 3'($urandom_range(5, 7));
            k  = ($urandom_range(0, 9) == 0) ? key_t'($urandom) : key_pool[$urandom_range(0, 23)];
            nk = ($urandom_range(0, 9) == 0) ? key_t'($urandom) : key_pool[$urandom_range(0, 23)];
            send_word(kind, k, nk, 6'($urandom_range(0, 63)));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        req_ch.valid = 1'b0;
        req_ch.kind  = '0;
        req_ch.key   = '0;
        req_ch.new_key = '0;
        req_ch.bucket  = '0;
        mismatches   = 0;
        words_sent   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        hold_request = 0;
        modulus_reg  = 64;
        for (int b = 0; b < MAX_BUCKETS; b++)
            bucket_len[b] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_operations();
        test_full_bucket();
        test_backpressure();
        test_random(7'd7, 30);
        test_random(7'd1, 25);
        test_random(7'd64, 25);
        test_random(7'd0, 15);
        test_random(7'd127, 15);
        test_random(7'd3, 15);
        drain();

        $display("covered %0d words and %0d results over bucket counts 64, 2, 7, 1, 0, 127, 3",
                 words_sent, results_seen);
        $display("full buckets, bad and empty lists, spare kinds and a long output stall included");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: filelist.f
design/htsb_pkg.sv
design/htsb_if.sv
design/htsb_mod.sv
design/htsb_core.sv
design/hash_table_sorted_buckets.sv
tb/tb_hash_table_sorted_buckets.sv
